// File: sv/tcg_pkg.sv
// Shared types, constants and the colour conversion for the glyph renderer.
package tcg_pkg;

   localparam int ADDR_W      = 9;
   localparam int WORD_W      = 16;
   localparam int CODE_W      = 8;
   localparam int COL_W       = 6;
   localparam int ROW_W       = 5;
   localparam int RGB_W       = 24;
   localparam int PAL_ENTRIES = 64;
   localparam int PAL_IDX_W   = 6;
   localparam int LINE_W      = 3;

   localparam logic [LINE_W-1:0] LAST_LINE = 3'd7;

   typedef enum logic [1:0] {
      OP_RENDER  = 2'd0,
      OP_FONT_WR = 2'd1,
      OP_PAL_WR  = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] store_address;
      logic [WORD_W-1:0] write_data;
      logic [WORD_W-1:0] char_word;
      logic              odd_column;
      logic [WORD_W-1:0] attr_word;
      logic              blink_phase;
      logic [COL_W-1:0]  cell_col;
      logic [ROW_W-1:0]  cell_row;
   } req_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] glyph0_raw;
      logic [WORD_W-1:0] glyph1_raw;
      logic              glyph0_ok;
      logic              glyph1_ok;
      logic [WORD_W-1:0] fg_raw;
      logic [WORD_W-1:0] bg_raw;
      logic              blink_on;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } fetch_type;

   typedef struct packed {
      logic [WORD_W-1:0] glyph0;
      logic [WORD_W-1:0] glyph1;
      logic [RGB_W-1:0]  fg_rgb;
      logic [RGB_W-1:0]  bg_rgb;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } cell_type;

   // 5-bit red/green/blue fields scaled by 8; bit 15 is dropped
   function automatic logic [RGB_W-1:0] to_rgb888(input logic [WORD_W-1:0] c);
      return {c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
   endfunction

endpackage

// File: sv/tcg_store.sv
// Font and palette stores: write beats and registered glyph/colour lookups.
module tcg_store #(
   parameter int FONT_WORDS = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  tcg_pkg::req_item_type item,
   output logic                 item_taken,
   input  logic                 fetch_ready,
   output logic                 fetch_valid,
   output tcg_pkg::fetch_type   fetch
);

   // even words are glyph word 0, odd words glyph word 1
   localparam int EVEN_DEPTH = (FONT_WORDS + 1) / 2;
   localparam int ODD_DEPTH  = FONT_WORDS / 2;
   localparam int EIDX_W     = $clog2(EVEN_DEPTH);
   localparam int OIDX_W     = $clog2(ODD_DEPTH);

   logic [tcg_pkg::WORD_W-1:0] even_mem [EVEN_DEPTH];
   logic [tcg_pkg::WORD_W-1:0] odd_mem  [ODD_DEPTH];
   logic [tcg_pkg::WORD_W-1:0] pal_mem  [tcg_pkg::PAL_ENTRIES];

   logic                        fetch_valid_ff, fetch_valid_in;
   tcg_pkg::fetch_type          fetch_ff;
   logic                        advance;
   logic                        is_render, render_take;
   logic                        font_wr, pal_wr;
   logic [tcg_pkg::CODE_W-1:0]  code;
   logic [tcg_pkg::CODE_W-1:0]  wr_word;

   assign advance     = !fetch_valid_ff || fetch_ready;
   assign is_render   = item.opcode == tcg_pkg::OP_RENDER;
   assign render_take = item_valid && is_render && advance;
   // writes and unused codes never wait on the lookup stage
   assign item_taken  = item_valid && (!is_render || advance);

   assign font_wr = item_valid && (item.opcode == tcg_pkg::OP_FONT_WR)
                    && ({1'b0, item.store_address} < 10'(FONT_WORDS));
   assign pal_wr  = item_valid && (item.opcode == tcg_pkg::OP_PAL_WR)
                    && (item.store_address < 9'(tcg_pkg::PAL_ENTRIES));
   assign wr_word = item.store_address[8:1];

   assign code = item.odd_column ? item.char_word[15:8] : item.char_word[7:0];

   assign fetch_valid_in = advance ? render_take : fetch_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_valid_ff <= 1'b0;
      end else begin
         fetch_valid_ff <= fetch_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (font_wr && !item.store_address[0]) begin
         even_mem[wr_word[EIDX_W-1:0]] <= item.write_data;
      end
      if (font_wr && item.store_address[0]) begin
         odd_mem[wr_word[OIDX_W-1:0]] <= item.write_data;
      end
      if (pal_wr) begin
         pal_mem[item.store_address[tcg_pkg::PAL_IDX_W-1:0]] <= item.write_data;
      end
   end

   // hold the lookup results while the next stage is stalled
   always_ff @(posedge clock) begin
      if (render_take) begin
         fetch_ff.glyph0_raw <= even_mem[code[EIDX_W-1:0]];
         fetch_ff.glyph1_raw <= odd_mem[code[OIDX_W-1:0]];
         fetch_ff.glyph0_ok  <= {1'b0, code} < 9'(EVEN_DEPTH);
         fetch_ff.glyph1_ok  <= {1'b0, code} < 9'(ODD_DEPTH);
         fetch_ff.fg_raw     <= pal_mem[item.attr_word[11:6]];
         fetch_ff.bg_raw     <= pal_mem[item.attr_word[5:0]];
         fetch_ff.blink_on   <= item.blink_phase & item.attr_word[12];
         fetch_ff.col        <= item.cell_col;
         fetch_ff.row        <= item.cell_row;
      end
   end

   assign fetch_valid = fetch_valid_ff;
   assign fetch       = fetch_ff;

endmodule

// File: sv/tcg_color.sv
// Colour stage: glyph range masking, blink and RGB888 expansion.
module tcg_color (
   input  logic               clock,
   input  logic               reset,
   input  logic               fetch_valid,
   input  tcg_pkg::fetch_type fetch,
   output logic               fetch_ready,
   input  logic               cell_ready,
   output logic               cell_valid,
   output tcg_pkg::cell_type  cell_data
);

   logic                       cell_valid_ff, cell_valid_in;
   tcg_pkg::cell_type          cell_ff, cell_in;
   logic [tcg_pkg::WORD_W-1:0] fg_sel;

   assign fetch_ready = !cell_valid_ff || cell_ready;

   // blink off phase: draw the foreground in the background colour
   assign fg_sel = fetch.blink_on ? fetch.bg_raw : fetch.fg_raw;

   always_comb begin
      cell_in.glyph0 = fetch.glyph0_ok ? fetch.glyph0_raw : '0;
      cell_in.glyph1 = fetch.glyph1_ok ? fetch.glyph1_raw : '0;
      cell_in.fg_rgb = tcg_pkg::to_rgb888(fg_sel);
      cell_in.bg_rgb = tcg_pkg::to_rgb888(fetch.bg_raw);
      cell_in.col    = fetch.col;
      cell_in.row    = fetch.row;
   end

   assign cell_valid_in = fetch_ready ? fetch_valid : cell_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= 1'b0;
      end else begin
         cell_valid_ff <= cell_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_ready && fetch_valid) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_valid = cell_valid_ff;
   assign cell_data  = cell_ff;

endmodule

// File: sv/tcg_line_seq.sv
// Line sequencer: walks a cell's eight pixel lines into the result register.
module tcg_line_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cell_valid,
   input  tcg_pkg::cell_type           cell_data,
   output logic                        cell_ready,
   output logic                        rsp_valid,
   output logic [tcg_pkg::COL_W-1:0]   rsp_out_col,
   output logic [tcg_pkg::ROW_W-1:0]   rsp_out_row,
   output logic [tcg_pkg::LINE_W-1:0]  rsp_line_index,
   output logic [tcg_pkg::RGB_W-1:0]   rsp_pixel0,
   output logic [tcg_pkg::RGB_W-1:0]   rsp_pixel1,
   output logic [tcg_pkg::RGB_W-1:0]   rsp_pixel2,
   output logic [tcg_pkg::RGB_W-1:0]   rsp_pixel3,
   output logic                        rsp_last_line
);

   logic                        active_ff, active_in;
   logic [tcg_pkg::LINE_W-1:0]  line_ff, line_in;
   tcg_pkg::cell_type           cur_ff;
   logic                        load, at_last;

   logic                        out_valid_ff;
   logic [tcg_pkg::COL_W-1:0]   out_col_ff;
   logic [tcg_pkg::ROW_W-1:0]   out_row_ff;
   logic [tcg_pkg::LINE_W-1:0]  out_line_ff;
   logic [tcg_pkg::RGB_W-1:0]   out_pix0_ff, out_pix1_ff, out_pix2_ff, out_pix3_ff;
   logic                        out_last_ff;

   assign at_last    = line_ff == tcg_pkg::LAST_LINE;
   assign cell_ready = !active_ff || at_last;
   assign load       = cell_valid && cell_ready;

   always_comb begin
      active_in = active_ff;
      line_in   = line_ff;
      if (load) begin
         active_in = 1'b1;
         line_in   = '0;
      end else if (active_ff) begin
         active_in = !at_last;
         line_in   = line_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         line_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         line_ff      <= line_in;
         out_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= cell_data;
      end
   end

   // upper byte of each glyph word is the left pixel of its pair
   always_ff @(posedge clock) begin
      out_col_ff  <= cur_ff.col;
      out_row_ff  <= cur_ff.row;
      out_line_ff <= line_ff;
      out_last_ff <= at_last;
      out_pix0_ff <= cur_ff.glyph0[{1'b1, line_ff}] ? cur_ff.fg_rgb : cur_ff.bg_rgb;
      out_pix1_ff <= cur_ff.glyph0[{1'b0, line_ff}] ? cur_ff.fg_rgb : cur_ff.bg_rgb;
      out_pix2_ff <= cur_ff.glyph1[{1'b1, line_ff}] ? cur_ff.fg_rgb : cur_ff.bg_rgb;
      out_pix3_ff <= cur_ff.glyph1[{1'b0, line_ff}] ? cur_ff.fg_rgb : cur_ff.bg_rgb;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_line_index = out_line_ff;
   assign rsp_pixel0     = out_pix0_ff;
   assign rsp_pixel1     = out_pix1_ff;
   assign rsp_pixel2     = out_pix2_ff;
   assign rsp_pixel3     = out_pix3_ff;
   assign rsp_last_line  = out_last_ff;

endmodule

// File: sv/text_cell_glyph_renderer.sv
// Top level of the text-cell glyph renderer: input register and stage chain.
//
//   channel   direction  handshake                   payload
//   request   in         start & !busy               req_* (opcode, store, cell fields)
//   response  out        rsp_valid, one-cycle beat   rsp_* (position, line, 4 pixels)
//
// A render beat yields eight response beats, one per cycle, top line first;
// the line sequencer sets the sustained rate, loading the next cell on the last line.
// Font and palette write beats are taken one per cycle while busy is low and yield no response.
// The first line of a cell passes the input register, store lookup, colour stage,
// line sequencer and result register, in that order, before it leaves.
// busy rises only when a render sits in the input register behind a full
// chain; the response side never stalls. Synchronous reset clears all valid
// state; the stores hold no reset value and must be written before use.
module text_cell_glyph_renderer #(
   parameter int FONT_WORDS = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_opcode,
   input  logic [tcg_pkg::ADDR_W-1:0]  req_store_address,
   input  logic [tcg_pkg::WORD_W-1:0]  req_write_data,
   input  logic [tcg_pkg::WORD_W-1:0]  req_char_word,
   input  logic                        req_odd_column,
   input  logic [tcg_pkg::WORD_W-1:0]  req_attr_word,
   input  logic                        req_blink_phase,
   input  logic [tcg_pkg::COL_W-1:0]   req_cell_col,
   input  logic [tcg_pkg::ROW_W-1:0]   req_cell_row,
   output logic                        rsp_valid,
   output logic [tcg_pkg::COL_W-1:0]   rsp_out_col,
   output logic [tcg_pkg::ROW_W-1:0]   rsp_out_row,
   output logic [tcg_pkg::LINE_W-1:0]  rsp_line_index,
   output logic [tcg_pkg::RGB_W-1:0]   rsp_pixel0,
   output logic [tcg_pkg::RGB_W-1:0]   rsp_pixel1,
   output logic [tcg_pkg::RGB_W-1:0]   rsp_pixel2,
   output logic [tcg_pkg::RGB_W-1:0]   rsp_pixel3,
   output logic                        rsp_last_line
);

   logic                   in_valid_ff, in_valid_in;
   tcg_pkg::req_item_type  in_item_ff;
   logic                   accept, item_taken;

   logic                   fetch_valid, fetch_ready;
   tcg_pkg::fetch_type     fetch;
   logic                   cell_valid, cell_ready;
   tcg_pkg::cell_type      cell_data;

   // busy: the held beat cannot leave the input register this cycle
   assign busy   = in_valid_ff && !item_taken;
   assign accept = start && !busy;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (item_taken) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // capture the request beat; hold it until the store stage takes it
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.opcode        <= req_opcode;
         in_item_ff.store_address <= req_store_address;
         in_item_ff.write_data    <= req_write_data;
         in_item_ff.char_word     <= req_char_word;
         in_item_ff.odd_column    <= req_odd_column;
         in_item_ff.attr_word     <= req_attr_word;
         in_item_ff.blink_phase   <= req_blink_phase;
         in_item_ff.cell_col      <= req_cell_col;
         in_item_ff.cell_row      <= req_cell_row;
      end
   end

   // stores: writes land here, renders look up glyph words and colours
   tcg_store #(
      .FONT_WORDS (FONT_WORDS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (in_valid_ff),
      .item        (in_item_ff),
      .item_taken  (item_taken),
      .fetch_ready (fetch_ready),
      .fetch_valid (fetch_valid),
      .fetch       (fetch)
   );

   // colours: blink, out-of-font masking and RGB888 expansion
   tcg_color u_color (
      .clock       (clock),
      .reset       (reset),
      .fetch_valid (fetch_valid),
      .fetch       (fetch),
      .fetch_ready (fetch_ready),
      .cell_ready  (cell_ready),
      .cell_valid  (cell_valid),
      .cell_data   (cell_data)
   );

   // lines: eight response beats per cell, next cell follows without a gap
   tcg_line_seq u_line_seq (
      .clock          (clock),
      .reset          (reset),
      .cell_valid     (cell_valid),
      .cell_data      (cell_data),
      .cell_ready     (cell_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_line_index (rsp_line_index),
      .rsp_pixel0     (rsp_pixel0),
      .rsp_pixel1     (rsp_pixel1),
      .rsp_pixel2     (rsp_pixel2),
      .rsp_pixel3     (rsp_pixel3),
      .rsp_last_line  (rsp_last_line)
   );

endmodule

// File: sv/tcg_checker.sv
// Port-level checks on the renderer's response sequence, bound to the top level.
module tcg_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic [tcg_pkg::COL_W-1:0]   rsp_out_col,
   input logic [tcg_pkg::ROW_W-1:0]   rsp_out_row,
   input logic [tcg_pkg::LINE_W-1:0]  rsp_line_index,
   input logic                        rsp_last_line
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_line == (rsp_line_index == tcg_pkg::LAST_LINE)))
      else $error("last_line flag disagrees with line index");

   a_line_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_line |=>
         rsp_valid && (rsp_line_index == $past(rsp_line_index) + 3'd1))
      else $error("cell lines not emitted back to back");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_line |=> $stable(rsp_out_col) && $stable(rsp_out_row))
      else $error("cell position changed inside a cell");

   a_first_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> rsp_line_index == '0)
      else $error("cell did not start at the top line");

endmodule

bind text_cell_glyph_renderer tcg_checker u_tcg_checker (.*);
